// ===== rtl/mmc_pkg.sv =====
// Shared types, constants and register codes for the magnetometer min/max calibrator.
package mmc_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int SCALE_BITS     = SAMPLE_BITS + 1;
  localparam int RUN_BITS       = 10;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = (SCALE_BITS > RUN_BITS) ? SCALE_BITS : RUN_BITS;
  localparam int AXES           = 3;

  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

  // floor(half * 64 / 25) as half * RECIP >> (DIV_SHIFT - 6)
  localparam int              DIV_SHIFT  = SAMPLE_BITS + 11;
  localparam longint unsigned RECIP      = ((64'd1 << DIV_SHIFT) + 64'd24) / 64'd25;
  localparam int              RECIP_BITS = DIV_SHIFT - 4;
  localparam int              PROD_BITS  = SAMPLE_BITS + RECIP_BITS;
  localparam int              SCALE_LSB  = DIV_SHIFT - 6;

  typedef logic [SAMPLE_BITS-1:0]            smp_t;
  typedef logic [AXES-1:0][SAMPLE_BITS-1:0]  vec_t;
  typedef logic [AXES-1:0][SCALE_BITS-1:0]   scl_vec_t;
  typedef logic [AXES-1:0][PROD_BITS-1:0]    prod_vec_t;
  typedef logic [RUN_BITS-1:0]               run_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_STABLE_LIMIT = 3'd0,
    CFG_OFFSET_X     = 3'd1,
    CFG_OFFSET_Y     = 3'd2,
    CFG_OFFSET_Z     = 3'd3,
    CFG_SCALE_X      = 3'd4,
    CFG_SCALE_Y      = 3'd5,
    CFG_SCALE_Z      = 3'd6
  } cfg_reg_t;

  localparam run_t RST_STABLE_LIMIT = RUN_BITS'(200);
  localparam vec_t RST_OFFSET = {SAMPLE_BITS'(-71), SAMPLE_BITS'(16), SAMPLE_BITS'(30)};
  localparam scl_vec_t RST_SCALE = {SCALE_BITS'(294), SCALE_BITS'(312), SCALE_BITS'(310)};

  localparam smp_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam smp_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  typedef struct packed {
    run_t     stable_limit;
    vec_t     def_offset;
    scl_vec_t def_scale;
  } cfg_t;

  typedef struct packed {
    vec_t sample;
    vec_t axis_max;
    vec_t axis_min;
    logic changed;
    logic no_change_yet;
    logic calibrated;
  } trk_t;

  typedef struct packed {
    vec_t      sample;
    vec_t      offset;
    prod_vec_t prod;
    logic      changed;
    logic      no_change_yet;
    logic      calibrated;
  } iron_t;

endpackage

// ===== rtl/mmc_in_if.sv =====
// Sample channel: valid/ready handshake carrying one three-axis reading.
interface mmc_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mmc_pkg::SAMPLE_BITS-1:0]  mag_x;
  logic signed [mmc_pkg::SAMPLE_BITS-1:0]  mag_y;
  logic signed [mmc_pkg::SAMPLE_BITS-1:0]  mag_z;

  modport source (output valid, output mag_x, output mag_y, output mag_z, input ready);
  modport sink   (input valid, input mag_x, input mag_y, input mag_z, output ready);
endinterface

// ===== rtl/mmc_out_if.sv =====
// Result channel: valid/ready handshake carrying the sample, offsets, scales and flags.
interface mmc_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mmc_pkg::SAMPLE_BITS-1:0]  out_x;
  logic signed [mmc_pkg::SAMPLE_BITS-1:0]  out_y;
  logic signed [mmc_pkg::SAMPLE_BITS-1:0]  out_z;
  logic signed [mmc_pkg::SAMPLE_BITS-1:0]  offset_x;
  logic signed [mmc_pkg::SAMPLE_BITS-1:0]  offset_y;
  logic signed [mmc_pkg::SAMPLE_BITS-1:0]  offset_z;
  logic        [mmc_pkg::SCALE_BITS-1:0]   scale_x;
  logic        [mmc_pkg::SCALE_BITS-1:0]   scale_y;
  logic        [mmc_pkg::SCALE_BITS-1:0]   scale_z;
  logic                                    extreme_changed;
  logic                                    calibrated;

  modport source (
    output valid, output out_x, output out_y, output out_z,
    output offset_x, output offset_y, output offset_z,
    output scale_x, output scale_y, output scale_z,
    output extreme_changed, output calibrated,
    input ready
  );
  modport sink (
    input valid, input out_x, input out_y, input out_z,
    input offset_x, input offset_y, input offset_z,
    input scale_x, input scale_y, input scale_z,
    input extreme_changed, input calibrated,
    output ready
  );
endinterface

// ===== rtl/mmc_cfg_regs.sv =====
// Configuration registers: stable limit and per-axis default offsets and scales.
module mmc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mmc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mmc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output mmc_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stable_limit <= mmc_pkg::RST_STABLE_LIMIT;
      cfg.def_offset   <= mmc_pkg::RST_OFFSET;
      cfg.def_scale    <= mmc_pkg::RST_SCALE;
    end else if (cfg_write) begin
      case (cfg_index)
        mmc_pkg::CFG_STABLE_LIMIT: cfg.stable_limit  <= cfg_data[mmc_pkg::RUN_BITS-1:0];
        mmc_pkg::CFG_OFFSET_X:     cfg.def_offset[0] <= cfg_data[mmc_pkg::SAMPLE_BITS-1:0];
        mmc_pkg::CFG_OFFSET_Y:     cfg.def_offset[1] <= cfg_data[mmc_pkg::SAMPLE_BITS-1:0];
        mmc_pkg::CFG_OFFSET_Z:     cfg.def_offset[2] <= cfg_data[mmc_pkg::SAMPLE_BITS-1:0];
        mmc_pkg::CFG_SCALE_X:      cfg.def_scale[0]  <= cfg_data[mmc_pkg::SCALE_BITS-1:0];
        mmc_pkg::CFG_SCALE_Y:      cfg.def_scale[1]  <= cfg_data[mmc_pkg::SCALE_BITS-1:0];
        mmc_pkg::CFG_SCALE_Z:      cfg.def_scale[2]  <= cfg_data[mmc_pkg::SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/mmc_extreme.sv =====
// Extreme tracker stage: running per-axis max/min, unchanged-run counter, calibrated flag.
module mmc_extreme (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mmc_pkg::vec_t        in_sample,
  input  mmc_pkg::run_t        stable_limit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mmc_pkg::trk_t        out_data
);

  mmc_pkg::vec_t axis_max;
  mmc_pkg::vec_t axis_min;
  mmc_pkg::run_t unchanged_run;
  logic          done_flag;

  mmc_pkg::vec_t         axis_max_next;
  mmc_pkg::vec_t         axis_min_next;
  mmc_pkg::run_t         unchanged_run_next;
  logic                  done_flag_next;
  logic [mmc_pkg::AXES-1:0] gt;
  logic [mmc_pkg::AXES-1:0] lt;
  logic                  changed;
  logic                  take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    for (int a = 0; a < mmc_pkg::AXES; a++) begin
      gt[a] = $signed(in_sample[a]) > $signed(axis_max[a]);
      lt[a] = $signed(in_sample[a]) < $signed(axis_min[a]);
      axis_max_next[a] = gt[a] ? in_sample[a] : axis_max[a];
      axis_min_next[a] = lt[a] ? in_sample[a] : axis_min[a];
    end
    changed = (|gt) || (|lt);
    if (changed) begin
      unchanged_run_next = '0;
    end else if (unchanged_run == mmc_pkg::RUN_MAX) begin
      unchanged_run_next = unchanged_run;
    end else begin
      unchanged_run_next = unchanged_run + mmc_pkg::RUN_BITS'(1);
    end
    done_flag_next = done_flag || (!changed && (unchanged_run_next >= stable_limit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_max      <= {mmc_pkg::AXES{mmc_pkg::SAMPLE_MIN}};
      axis_min      <= {mmc_pkg::AXES{mmc_pkg::SAMPLE_MAX}};
      unchanged_run <= '0;
      done_flag     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        axis_max      <= axis_max_next;
        axis_min      <= axis_min_next;
        unchanged_run <= unchanged_run_next;
        done_flag     <= done_flag_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.sample        <= in_sample;
      out_data.axis_max      <= axis_max_next;
      out_data.axis_min      <= axis_min_next;
      out_data.changed       <= changed;
      out_data.no_change_yet <= $signed(axis_max_next[0]) < $signed(axis_min_next[0]);
      out_data.calibrated    <= done_flag_next;
    end
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done_flag |=> done_flag)
    else $error("calibrated flag dropped");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    (take && changed) |=> (unchanged_run == '0))
    else $error("run counter not cleared on extreme change");

  a_first_change: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.no_change_yet) |->
      ($signed(out_data.axis_max[0]) >= $signed(out_data.axis_min[0])))
    else $error("held values used before any extreme change");

endmodule

// ===== rtl/mmc_iron.sv =====
// Hard/soft iron stages: midpoint offset and half range, then scale multiply.
module mmc_iron (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mmc_pkg::trk_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output mmc_pkg::iron_t   out_data
);

  localparam int SB = mmc_pkg::SAMPLE_BITS;

  logic signed [SB:0]   sum   [mmc_pkg::AXES];
  logic signed [SB:0]   rnd   [mmc_pkg::AXES];
  logic signed [SB:0]   range [mmc_pkg::AXES];
  mmc_pkg::vec_t        off_c;
  mmc_pkg::vec_t        half_c;
  mmc_pkg::prod_vec_t   prod_c;

  logic                 mid_valid;
  logic                 mid_ready;
  mmc_pkg::vec_t        mid_sample;
  mmc_pkg::vec_t        held_offset;
  mmc_pkg::vec_t        held_half;
  logic                 mid_changed;
  logic                 mid_no_change_yet;
  logic                 mid_calibrated;

  localparam logic [mmc_pkg::RECIP_BITS-1:0] RECIP_W = mmc_pkg::RECIP_BITS'(mmc_pkg::RECIP);

  assign mid_ready = !out_valid || out_ready;
  assign in_ready  = !mid_valid || mid_ready;

  always_comb begin
    for (int a = 0; a < mmc_pkg::AXES; a++) begin
      sum[a] = $signed({in_data.axis_max[a][SB-1], in_data.axis_max[a]})
             + $signed({in_data.axis_min[a][SB-1], in_data.axis_min[a]});
      rnd[a] = sum[a] + $signed({{SB{1'b0}}, sum[a][SB]});
      off_c[a] = rnd[a][SB:1];
      range[a] = $signed({in_data.axis_max[a][SB-1], in_data.axis_max[a]})
               - $signed({off_c[a][SB-1], off_c[a]});
      half_c[a] = range[a][SB] ? '0 : range[a][SB-1:0];
      prod_c[a] = held_half[a] * RECIP_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        mid_valid <= 1'b1;
      end else if (mid_ready) begin
        mid_valid <= 1'b0;
      end
      if (mid_valid && mid_ready) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mid_sample        <= in_data.sample;
      mid_changed       <= in_data.changed;
      mid_no_change_yet <= in_data.no_change_yet;
      mid_calibrated    <= in_data.calibrated;
      if (in_data.changed) begin
        held_offset <= off_c;
        held_half   <= half_c;
      end
    end
    if (mid_valid && mid_ready) begin
      out_data.sample        <= mid_sample;
      out_data.offset        <= held_offset;
      out_data.prod          <= prod_c;
      out_data.changed       <= mid_changed;
      out_data.no_change_yet <= mid_no_change_yet;
      out_data.calibrated    <= mid_calibrated;
    end
  end

  a_half_bound: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.changed && !in_data.no_change_yet) |->
      (half_c[0] <= SB'(1 << (SB-1))))
    else $error("half range out of bounds");

  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled scale stage changed");

  a_scale_fits: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.no_change_yet) |->
      (out_data.prod[0][mmc_pkg::PROD_BITS-1:mmc_pkg::SCALE_LSB + mmc_pkg::SCALE_BITS] == '0))
    else $error("scale product overflows scale width");

endmodule

// ===== rtl/magnetometer_minmax_calibrator_top.sv =====
// Top level of the magnetometer min/max hard/soft iron calibrator.
// One sample transfer is taken per clock while the result channel is not stalled, and
// each produces exactly one result, passing through the input register, extreme tracker,
// offset/half-range stage, scale multiply and output register. The sustained rate of
// one sample per cycle is set by the extreme tracker, whose max/min and run-counter
// feedback closes within that stage's own registers.
// Offsets and scales show the default registers until the first extreme change on x,
// and a default register write takes effect on the next result. Write configuration
// only with no samples in flight. The scale is floor((max - offset) * 256 / 100).
module magnetometer_minmax_calibrator_top (
  input  logic                               clk,
  input  logic                               rst,
  mmc_in_if.sink                             sample,
  mmc_out_if.source                          result,
  input  logic                               cfg_write,
  input  logic [mmc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mmc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  mmc_pkg::cfg_t     cfg;

  logic              in_valid;
  mmc_pkg::vec_t     in_sample;
  logic              trk_ready;

  logic              trk_valid;
  mmc_pkg::trk_t     trk_data;
  logic              iron_ready;

  logic              iron_valid;
  mmc_pkg::iron_t    iron_data;
  logic              out_load;

  mmc_pkg::vec_t     offset_c;
  mmc_pkg::scl_vec_t scale_c;

  mmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign sample.ready = !in_valid || trk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      in_valid <= 1'b1;
    end else if (trk_ready) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_sample <= {sample.mag_z, sample.mag_y, sample.mag_x};
    end
  end

  mmc_extreme u_extreme (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (trk_ready),
    .in_sample    (in_sample),
    .stable_limit (cfg.stable_limit),
    .out_valid    (trk_valid),
    .out_ready    (iron_ready),
    .out_data     (trk_data)
  );

  mmc_iron u_iron (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (trk_valid),
    .in_ready  (iron_ready),
    .in_data   (trk_data),
    .out_valid (iron_valid),
    .out_ready (out_load),
    .out_data  (iron_data)
  );

  assign out_load = !result.valid || result.ready;

  always_comb begin
    for (int a = 0; a < mmc_pkg::AXES; a++) begin
      offset_c[a] = iron_data.no_change_yet ? cfg.def_offset[a] : iron_data.offset[a];
      scale_c[a]  = iron_data.no_change_yet ? cfg.def_scale[a]
                  : iron_data.prod[a][mmc_pkg::SCALE_LSB +: mmc_pkg::SCALE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (iron_valid && out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (iron_valid && out_load) begin
      result.out_x           <= iron_data.sample[0];
      result.out_y           <= iron_data.sample[1];
      result.out_z           <= iron_data.sample[2];
      result.offset_x        <= offset_c[0];
      result.offset_y        <= offset_c[1];
      result.offset_z        <= offset_c[2];
      result.scale_x         <= scale_c[0];
      result.scale_y         <= scale_c[1];
      result.scale_z         <= scale_c[2];
      result.extreme_changed <= iron_data.changed;
      result.calibrated      <= iron_data.calibrated;
    end
  end

endmodule
